[src/risc_instruction_executor_top_defines.svh]
// Assertion macros used by the executor's checker.
// Depends on nothing; included by name where assertions are written.
`ifndef RISC_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH
`define RISC_INSTRUCTION_EXECUTOR_TOP_DEFINES_SVH

// same-cycle implication
`define RIE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RIE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/rie_pkg.sv]
// Shared types and constants of the instruction executor.
// No dependencies; imported by every module of the block.
package rie_pkg;

	localparam int REG_COUNT     = 32;
	localparam int RIDX_W        = $clog2(REG_COUNT);
	localparam int MEM_WORDS_DEF = 2048;
	localparam int MIDX_W        = 11;

	localparam logic KIND_EXEC    = 1'b0;
	localparam logic KIND_PRELOAD = 1'b1;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_MULI  = 4'd2;
	localparam logic [3:0] OP_ADDI  = 4'd3;
	localparam logic [3:0] OP_BNE   = 4'd4;
	localparam logic [3:0] OP_ANDI  = 4'd5;
	localparam logic [3:0] OP_XORI  = 4'd6;
	localparam logic [3:0] OP_JMP   = 4'd7;
	localparam logic [3:0] OP_SHL   = 4'd8;
	localparam logic [3:0] OP_SHR   = 4'd9;
	localparam logic [3:0] OP_LOAD  = 4'd10;
	localparam logic [3:0] OP_STORE = 4'd11;

	typedef struct packed {
		logic               kind;
		logic [31:0]        instruction_word;
		logic [9:0]         instruction_address;
		logic [MIDX_W-1:0]  preload_address;
		logic signed [31:0] preload_data;
	} in_t;

	typedef struct packed {
		logic signed [31:0] next_address;
		logic               redirect;
		logic               reg_write;
		logic [RIDX_W-1:0]  reg_index;
		logic signed [31:0] reg_value;
		logic               mem_write;
		logic [MIDX_W-1:0]  mem_index;
		logic signed [31:0] mem_value;
	} out_t;

endpackage

[src/rie_chan_if.sv]
// Valid/ready channel carrying one payload beat of type T.
// Depends on nothing; payload types come from rie_pkg.
interface rie_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/rie_regfile.sv]
// Register file: synchronous two-read one-write memory, valid bits give zero reset.
// Depends on rie_pkg.
module rie_regfile (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [rie_pkg::RIDX_W-1:0] ra_idx,
	input  logic [rie_pkg::RIDX_W-1:0] rb_idx,
	input  logic                       we,
	input  logic [rie_pkg::RIDX_W-1:0] wa,
	input  logic [31:0]                wd,
	output logic [31:0]                ra_data,
	output logic [31:0]                rb_data
);
	import rie_pkg::*;

	logic [31:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;
	logic [31:0]          ra_q, rb_q;
	logic                 rav_q, rbv_q;

	always_ff @(posedge clk) begin
		ra_q <= mem[ra_idx];
		rb_q <= mem[rb_idx];
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rav_q <= 1'b0;
			rbv_q <= 1'b0;
		end else begin
			rav_q <= vld_q[ra_idx];
			rbv_q <= vld_q[rb_idx];
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
		end
	end

	assign ra_data = rav_q ? ra_q : '0;
	assign rb_data = rb_q & {32{rbv_q}};
endmodule

[src/rie_amod.sv]
// Data address reduction modulo the memory depth, by reciprocal multiply.
// Three stages (s2 to s4) aligned with the executor pipeline. Depends on rie_pkg.
module rie_amod #(
	parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         en_s3,
	input  logic                         en_s4,
	input  logic [31:0]                  x_s2,
	output logic [$clog2(MEM_WORDS)-1:0] addr_s4
);
	import rie_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int QW = 33 - AW;
	localparam logic [32:0] RECIP = 33'(64'h1_0000_0000 / 64'(MEM_WORDS));
	localparam logic [16:0] NW = 17'(MEM_WORDS);

	logic [64:0]   prod;
	logic [QW-1:0] q_s3;
	logic [31:0]   x_s3, x_s4, qn_s4, rem;

	assign prod = 65'(x_s2) * 65'(RECIP);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			q_s3 <= prod[32 +: QW];
			x_s3 <= x_s2;
		end
		if (en_s4) begin
			qn_s4 <= 32'(q_s3) * 32'(NW);
			x_s4  <= x_s3;
		end
	end

	// estimate is low by at most one: remainder below twice the depth
	assign rem     = x_s4 - qn_s4;
	assign addr_s4 = (rem >= 32'(MEM_WORDS)) ? AW'(rem - 32'(MEM_WORDS)) : AW'(rem);
endmodule

[src/rie_dmem.sv]
// Data memory: one synchronous read/write port, cleared by a sweep after reset.
// Depends on rie_pkg.
module rie_dmem #(
	parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         we,
	input  logic [$clog2(MEM_WORDS)-1:0] addr,
	input  logic [31:0]                  wdata,
	output logic [31:0]                  rdata,
	output logic                         clear_done
);
	import rie_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);
	localparam int CW = $clog2(MEM_WORDS + 1);

	logic [31:0]   mem [MEM_WORDS];
	logic [CW-1:0] clr_q;
	logic [31:0]   rd_q;

	assign clear_done = (clr_q == CW'(MEM_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clear_done) begin
			clr_q <= clr_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (!clear_done) begin
			mem[clr_q[AW-1:0]] <= '0;
		end else if (en && we) begin
			mem[addr] <= wdata;
		end
		if (en) begin
			rd_q <= mem[addr];
		end
	end

	assign rdata = rd_q;
endmodule

[src/risc_instruction_executor_top.sv]
// Beats pass stages s1 to s5 and an output register; one beat per cycle unless a load
// hazard or result back-pressure stalls. A load whose destination is read by one of
// the next three instructions holds that instruction in decode until the load is in
// s5 and the data memory read returns. Reset: register file reads zero at once; the
// data memory is swept to zero over MEM_WORDS words (2048 by default), input held off.
module risc_instruction_executor_top #(
	parameter int MEM_WORDS = rie_pkg::MEM_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rie_chan_if.sink   instr,
	rie_chan_if.source result
);
	import rie_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	typedef struct packed {
		logic [31:0]       next_address;
		logic              redirect;
		logic              wr;
		logic [RIDX_W-1:0] dest;
		logic [31:0]       value;
		logic              is_load;
		logic              mem_acc;
		logic              mem_wr;
		logic [31:0]       wdata;
	} stage_t;

	logic              v_s1, v_s2, v_s3, v_s4, v_s5, ov_q;
	in_t               in_s1;
	stage_t            st_s2, st_s3, st_s4, st_s5, st_n;
	logic [31:0]       x_s2, x_n;
	logic [AW-1:0]     addr_s4, addr_s5;
	out_t              out_q;
	logic              wbv_q;
	logic [RIDX_W-1:0] wbi_q;
	logic [31:0]       wbd_q;

	logic adv1, adv2, adv3, adv4, adv5;
	logic free1, free2, free3, free4, free5;
	logic haz, in_acc, clear_done;

	logic [3:0]        op;
	logic [RIDX_W-1:0] r1, r2, r3, ra_idx, rb_idx, dst;
	logic [12:0]       shamt;
	logic [31:0]       imm, a, b, rfa, rfb, pc1, mrd, wb_val;
	logic              hd;

	function automatic logic ld_match(input logic [RIDX_W-1:0] idx);
		return (v_s2 && st_s2.is_load && st_s2.wr && st_s2.dest == idx) ||
			(v_s3 && st_s3.is_load && st_s3.wr && st_s3.dest == idx) ||
			(v_s4 && st_s4.is_load && st_s4.wr && st_s4.dest == idx);
	endfunction

	function automatic logic [31:0] fwd(input logic [RIDX_W-1:0] idx, input logic [31:0] rf);
		logic [31:0] r;
		if (v_s2 && st_s2.wr && st_s2.dest == idx) begin
			r = st_s2.value;
		end else if (v_s3 && st_s3.wr && st_s3.dest == idx) begin
			r = st_s3.value;
		end else if (v_s4 && st_s4.wr && st_s4.dest == idx) begin
			r = st_s4.value;
		end else if (v_s5 && st_s5.wr && st_s5.dest == idx) begin
			r = st_s5.is_load ? mrd : st_s5.value;
		end else if (wbv_q && wbi_q == idx) begin
			r = wbd_q;
		end else begin
			r = rf;
		end
		return r;
	endfunction

	// pipeline flow
	assign free5  = !v_s5 || adv5;
	assign adv5   = v_s5 && (!ov_q || result.ready);
	assign adv4   = v_s4 && free5;
	assign free4  = !v_s4 || adv4;
	assign adv3   = v_s3 && free4;
	assign free3  = !v_s3 || adv3;
	assign adv2   = v_s2 && free3;
	assign free2  = !v_s2 || adv2;
	assign adv1   = v_s1 && free2 && !haz;
	assign free1  = !v_s1 || adv1;
	assign instr.ready = free1 && clear_done;
	assign in_acc = instr.valid && instr.ready;

	// decode
	assign op    = in_s1.instruction_word[31:28];
	assign r1    = in_s1.instruction_word[27:23];
	assign r2    = in_s1.instruction_word[22:18];
	assign r3    = in_s1.instruction_word[17:13];
	assign shamt = in_s1.instruction_word[12:0];
	assign imm   = {{14{in_s1.instruction_word[17]}}, in_s1.instruction_word[17:0]};
	assign pc1   = 32'(in_s1.instruction_address) + 32'd1;

	assign ra_idx = in_acc ? instr.data.instruction_word[27:23] : r1;
	assign rb_idx = in_acc ? instr.data.instruction_word[22:18] : r2;

	always_comb begin
		haz = v_s1 && (in_s1.kind == KIND_EXEC) && (ld_match(r1) || ld_match(r2));
		a   = fwd(r1, rfa);
		b   = fwd(r2, rfb);
	end

	always_comb begin
		st_n = '0;
		x_n  = '0;
		hd   = 1'b0;
		dst  = r1;
		if (in_s1.kind == KIND_PRELOAD) begin
			st_n.mem_acc = 1'b1;
			st_n.mem_wr  = 1'b1;
			st_n.wdata   = in_s1.preload_data;
			x_n          = 32'(in_s1.preload_address);
		end else begin
			st_n.next_address = pc1;
			case (op)
				OP_ADD: begin
					hd = 1'b1; dst = r3; st_n.value = a + b;
				end
				OP_SUB: begin
					hd = 1'b1; dst = r3; st_n.value = a - b;
				end
				OP_MULI: begin
					hd = 1'b1; st_n.value = b * imm;
				end
				OP_ADDI: begin
					hd = 1'b1; st_n.value = b + imm;
				end
				OP_BNE: begin
					if (a != b) begin
						st_n.next_address = pc1 + imm;
						st_n.redirect     = 1'b1;
					end
				end
				OP_ANDI: begin
					hd = 1'b1; st_n.value = b & imm;
				end
				OP_XORI: begin
					hd = 1'b1; st_n.value = b ^ imm;
				end
				OP_JMP: begin
					st_n.next_address = (pc1 & 32'hF000_0000) |
						{4'h0, in_s1.instruction_word[27:0]};
					st_n.redirect = 1'b1;
				end
				OP_SHL: begin
					hd = 1'b1;
					st_n.value = (shamt < 13'd32) ? (b << shamt[4:0]) : '0;
				end
				OP_SHR: begin
					hd = 1'b1;
					st_n.value = (shamt < 13'd32) ? (b >> shamt[4:0]) : '0;
				end
				OP_LOAD: begin
					hd = 1'b1;
					st_n.is_load = 1'b1;
					st_n.mem_acc = 1'b1;
					x_n = b + imm;
				end
				OP_STORE: begin
					st_n.mem_acc = 1'b1;
					st_n.mem_wr  = 1'b1;
					st_n.wdata   = a;
					x_n = b + imm;
				end
				default: begin
				end
			endcase
			st_n.wr = hd && (dst != '0);
			if (st_n.wr) begin
				st_n.dest = dst;
			end else begin
				st_n.value = '0;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			ov_q  <= 1'b0;
			wbv_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				v_s3 <= 1'b1;
			end else if (adv3) begin
				v_s3 <= 1'b0;
			end
			if (adv3) begin
				v_s4 <= 1'b1;
			end else if (adv4) begin
				v_s4 <= 1'b0;
			end
			if (adv4) begin
				v_s5 <= 1'b1;
			end else if (adv5) begin
				v_s5 <= 1'b0;
			end
			if (adv5) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			wbv_q <= adv5 && st_s5.wr;
		end
	end

	assign wb_val = st_s5.is_load ? mrd : st_s5.value;

	// payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_s1 <= instr.data;
		end
		if (adv1) begin
			st_s2 <= st_n;
			x_s2  <= x_n;
		end
		if (adv2) begin
			st_s3 <= st_s2;
		end
		if (adv3) begin
			st_s4 <= st_s3;
		end
		if (adv4) begin
			st_s5   <= st_s4;
			addr_s5 <= addr_s4;
		end
		if (adv5) begin
			out_q.next_address <= st_s5.next_address;
			out_q.redirect     <= st_s5.redirect;
			out_q.reg_write    <= st_s5.wr;
			out_q.reg_index    <= st_s5.dest;
			out_q.reg_value    <= st_s5.wr ? wb_val : '0;
			out_q.mem_write    <= st_s5.mem_wr;
			out_q.mem_index    <= st_s5.mem_acc ? MIDX_W'(addr_s5) : '0;
			out_q.mem_value    <= st_s5.mem_acc ? (st_s5.is_load ? mrd : st_s5.wdata) : '0;
			wbi_q              <= st_s5.dest;
			wbd_q              <= wb_val;
		end
	end

	assign result.valid = ov_q;
	assign result.data  = out_q;

	rie_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.ra_idx  (ra_idx),
		.rb_idx  (rb_idx),
		.we      (adv5 && st_s5.wr),
		.wa      (st_s5.dest),
		.wd      (wb_val),
		.ra_data (rfa),
		.rb_data (rfb)
	);

	rie_amod #(.MEM_WORDS(MEM_WORDS)) u_amod (
		.clk     (clk),
		.en_s3   (adv2),
		.en_s4   (adv3),
		.x_s2    (x_s2),
		.addr_s4 (addr_s4)
	);

	rie_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (adv4 && st_s4.mem_acc),
		.we         (st_s4.mem_wr),
		.addr       (addr_s4),
		.wdata      (st_s4.wdata),
		.rdata      (mrd),
		.clear_done (clear_done)
	);
endmodule

[src/rie_chk.sv]
// Port-level checker for the executor, bound to the top level.
// Depends on rie_pkg and risc_instruction_executor_top_defines.svh.
`include "risc_instruction_executor_top_defines.svh"

module rie_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          instr_valid,
	input logic          instr_ready,
	input logic          result_valid,
	input logic          result_ready,
	input rie_pkg::out_t result_data
);
	import rie_pkg::*;

	logic [3:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 4'(instr_valid && instr_ready)
				- 4'(result_valid && result_ready);
		end
	end

	`RIE_ASSERT_NXT(a_res_hold, clk, arst_n, result_valid && !result_ready, result_valid, "result beat dropped while stalled")
	`RIE_ASSERT_NXT(a_res_stable, clk, arst_n, result_valid && !result_ready, $stable(result_data), "result beat changed while stalled")
	`RIE_ASSERT_IMP(a_no_orphan, clk, arst_n, result_valid, inflight_q != 4'd0, "result beat without a pending input beat")
	`RIE_ASSERT_IMP(a_redirect_pure, clk, arst_n, result_valid && result_data.redirect, !result_data.reg_write && !result_data.mem_write, "redirect with a write")
	`RIE_ASSERT_IMP(a_reg_idle_zero, clk, arst_n, result_valid && !result_data.reg_write, result_data.reg_index == '0 && result_data.reg_value == '0, "register fields set without a write")
endmodule

bind risc_instruction_executor_top rie_chk u_rie_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.instr_valid  (instr.valid),
	.instr_ready  (instr.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

[bench/tb_risc_instruction_executor_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for risc_instruction_executor_top: directed table then random beats.
// Results are checked against a row's fixed want, else an in-bench register and memory copy.
// Depends on rie_pkg, rie_chan_if and the executor RTL.
module tb_risc_instruction_executor_top;
	import rie_pkg::*;

	typedef struct {
		in_t  stim;
		bit   typed;
		out_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   quiet = 1'b0;
	int   mismatches = 0;
	int   results_seen = 0;

	logic [31:0] arch_regs [REG_COUNT];
	logic [31:0] data_words [MEM_WORDS_DEF];
	out_t        pending_results [$];

	rie_chan_if #(.T(in_t))  instr_ch ();
	rie_chan_if #(.T(out_t)) result_ch ();

	risc_instruction_executor_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_risc_instruction_executor_top failed");
		$finish;
	end

	function automatic logic [31:0] iw(logic [3:0] op, logic [4:0] ra, logic [4:0] rb,
			logic [17:0] low);
		return {op, ra, rb, low};
	endfunction

	function automatic in_t ex(logic [31:0] w, logic [9:0] pc);
		in_t b;
		b = '0;
		b.kind = KIND_EXEC;
		b.instruction_word = w;
		b.instruction_address = pc;
		return b;
	endfunction

	function automatic in_t pre(logic [MIDX_W-1:0] addr, logic [31:0] word);
		in_t b;
		b = '0;
		b.kind = KIND_PRELOAD;
		b.preload_address = addr;
		b.preload_data = word;
		return b;
	endfunction

	function automatic out_t res(logic [31:0] nxt, logic rdr, logic [RIDX_W-1:0] ri,
			logic [31:0] rv, logic mw, logic [MIDX_W-1:0] mi, logic [31:0] mv);
		out_t r;
		r.next_address = nxt;
		r.redirect = rdr;
		r.reg_write = (ri != '0);
		r.reg_index = ri;
		r.reg_value = rv;
		r.mem_write = mw;
		r.mem_index = mi;
		r.mem_value = mv;
		return r;
	endfunction

	function automatic row_t chk(in_t s);
		row_t r;
		r.stim = s;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t want(in_t s, out_t w);
		row_t r;
		r.stim = s;
		r.typed = 1'b1;
		r.want = w;
		return r;
	endfunction

	// architectural effect of one beat on the bench's register file and memory
	function automatic out_t retire_instruction(in_t b);
		out_t              r;
		logic [31:0]       w;
		logic [3:0]        op;
		logic [4:0]        ra, rb, rc;
		logic [12:0]       sh;
		logic [31:0]       imm, x, y, val, sum;
		logic [MIDX_W-1:0] idx;
		int                dst;
		r = '0;
		if (b.kind == KIND_PRELOAD) begin
			data_words[b.preload_address] = b.preload_data;
			r.mem_write = 1'b1;
			r.mem_index = b.preload_address;
			r.mem_value = b.preload_data;
			return r;
		end
		w = b.instruction_word;
		op = w[31:28];
		ra = w[27:23];
		rb = w[22:18];
		rc = w[17:13];
		sh = w[12:0];
		imm = {{14{w[17]}}, w[17:0]};
		x = arch_regs[ra];
		y = arch_regs[rb];
		sum = y + imm;
		idx = sum[MIDX_W-1:0];
		dst = -1;
		val = '0;
		r.next_address = {22'b0, b.instruction_address} + 32'd1;
		case (op)
			OP_ADD: begin
				dst = int'(rc);
				val = x + y;
			end
			OP_SUB: begin
				dst = int'(rc);
				val = x - y;
			end
			OP_MULI: begin
				dst = int'(ra);
				val = y * imm;
			end
			OP_ADDI: begin
				dst = int'(ra);
				val = sum;
			end
			OP_BNE: begin
				if (x != y) begin
					r.next_address = {22'b0, b.instruction_address} + 32'd1 + imm;
					r.redirect = 1'b1;
				end
			end
			OP_ANDI: begin
				dst = int'(ra);
				val = y & imm;
			end
			OP_XORI: begin
				dst = int'(ra);
				val = y ^ imm;
			end
			OP_JMP: begin
				r.next_address = (({22'b0, b.instruction_address} + 32'd1) & 32'hF000_0000)
					| {4'b0, w[27:0]};
				r.redirect = 1'b1;
			end
			OP_SHL: begin
				dst = int'(ra);
				val = (sh < 13'd32) ? (y << sh) : 32'd0;
			end
			OP_SHR: begin
				dst = int'(ra);
				val = (sh < 13'd32) ? (y >> sh) : 32'd0;
			end
			OP_LOAD: begin
				dst = int'(ra);
				val = data_words[idx];
				r.mem_index = idx;
				r.mem_value = data_words[idx];
			end
			OP_STORE: begin
				data_words[idx] = x;
				r.mem_write = 1'b1;
				r.mem_index = idx;
				r.mem_value = x;
			end
			default: ;
		endcase
		if (dst > 0) begin
			arch_regs[dst] = val;
			r.reg_write = 1'b1;
			r.reg_index = dst[RIDX_W-1:0];
			r.reg_value = val;
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [4:0] pick_reg();
		if ($urandom_range(0, 3) != 0)
			return 5'($urandom_range(0, 7));
		return 5'($urandom);
	endfunction

	function automatic in_t draw_item();
		in_t         b;
		logic [3:0]  op;
		logic [17:0] low;
		int          roll;
		b.kind = KIND_EXEC;
		b.instruction_word = $urandom;
		b.instruction_address = 10'($urandom);
		b.preload_address = 11'($urandom);
		b.preload_data = $urandom;
		roll = $urandom_range(0, 99);
		if (roll < 10) begin
			b.kind = KIND_PRELOAD;
			if ($urandom_range(0, 1) != 0)
				b.preload_address = 11'($urandom_range(0, 63));
			return b;
		end
		if (roll < 16)
			return b;
		op = (roll < 20) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
		case ($urandom_range(0, 3))
			0: low = 18'($urandom);
			1: low = 18'($urandom_range(0, 63));
			2: low = 18'h3FFFF - 18'($urandom_range(0, 63));
			default: low = {pick_reg(), 13'($urandom_range(0, 40))};
		endcase
		b.instruction_word = iw(op, pick_reg(), pick_reg(), low);
		return b;
	endfunction

	task automatic flag(string what);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t: %s", $time, what);
	endtask

	task automatic check_result(out_t got);
		out_t exp;
		if (pending_results.size() == 0) begin
			flag("result beat with nothing pending");
			return;
		end
		exp = pending_results.pop_front();
		if (got.next_address !== exp.next_address)
			flag($sformatf("next_address %h, want %h", got.next_address, exp.next_address));
		if (got.redirect !== exp.redirect)
			flag($sformatf("redirect %b, want %b", got.redirect, exp.redirect));
		if (got.reg_write !== exp.reg_write)
			flag($sformatf("reg_write %b, want %b", got.reg_write, exp.reg_write));
		if (got.reg_index !== exp.reg_index)
			flag($sformatf("reg_index %0d, want %0d", got.reg_index, exp.reg_index));
		if (got.reg_value !== exp.reg_value)
			flag($sformatf("reg_value %h, want %h", got.reg_value, exp.reg_value));
		if (got.mem_write !== exp.mem_write)
			flag($sformatf("mem_write %b, want %b", got.mem_write, exp.mem_write));
		if (got.mem_index !== exp.mem_index)
			flag($sformatf("mem_index %0d, want %0d", got.mem_index, exp.mem_index));
		if (got.mem_value !== exp.mem_value)
			flag($sformatf("mem_value %h, want %h", got.mem_value, exp.mem_value));
	endtask

	task automatic drive_beat(in_t b, bit typed, out_t w);
		out_t p;
		instr_ch.valid <= 1'b1;
		instr_ch.data <= b;
		@(posedge clk);
		while (!instr_ch.ready)
			@(posedge clk);
		p = retire_instruction(b);
		pending_results.push_back(typed ? w : p);
	endtask

	task automatic idle_in(int n);
		if (n > 0) begin
			instr_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		instr_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int hold;
		hold = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				check_result(result_ch.data);
				results_seen++;
				// long hold-off so the block backs up onto its input
				if (results_seen == 200)
					hold = 300;
			end
			if (hold == 0 && $urandom_range(0, 3) == 0)
				hold = pick_gap();
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		row_t plan [26];
		foreach (arch_regs[i])
			arch_regs[i] = '0;
		foreach (data_words[i])
			data_words[i] = '0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		plan = '{
			want(ex(iw(OP_ADD, 5'd1, 5'd2, {5'd3, 13'd0}), 10'd0),
				res(32'd1, 1'b0, 5'd3, 32'd0, 1'b0, 11'd0, 32'd0)),
			want(ex(iw(OP_ADDI, 5'd1, 5'd0, 18'h1FFFF), 10'd1023),
				res(32'd1024, 1'b0, 5'd1, 32'h0001_FFFF, 1'b0, 11'd0, 32'd0)),
			want(ex(iw(OP_ADDI, 5'd2, 5'd0, 18'h20000), 10'd5),
				res(32'd6, 1'b0, 5'd2, 32'hFFFE_0000, 1'b0, 11'd0, 32'd0)),
			want(ex(iw(OP_ADDI, 5'd0, 5'd0, 18'd5), 10'd6),
				res(32'd7, 1'b0, 5'd0, 32'd0, 1'b0, 11'd0, 32'd0)),
			want(pre(11'd2047, 32'h8000_0000),
				res(32'd0, 1'b0, 5'd0, 32'd0, 1'b1, 11'd2047, 32'h8000_0000)),
			want(pre(11'd0, 32'h7FFF_FFFF),
				res(32'd0, 1'b0, 5'd0, 32'd0, 1'b1, 11'd0, 32'h7FFF_FFFF)),
			chk(ex(iw(OP_LOAD, 5'd4, 5'd0, 18'h007FF), 10'd8)),
			chk(ex(iw(OP_LOAD, 5'd5, 5'd1, 18'd1), 10'd9)),
			chk(ex(iw(OP_SUB, 5'd0, 5'd1, {5'd6, 13'd0}), 10'd10)),
			chk(ex(iw(OP_ADD, 5'd2, 5'd2, {5'd7, 13'd0}), 10'd11)),
			chk(ex(iw(OP_MULI, 5'd8, 5'd1, 18'h3FFFF), 10'd12)),
			chk(ex(iw(OP_ANDI, 5'd9, 5'd2, 18'h3FFFF), 10'd13)),
			chk(ex(iw(OP_XORI, 5'd10, 5'd1, 18'h20000), 10'd14)),
			chk(ex(iw(OP_SHL, 5'd11, 5'd1, 18'd31), 10'd15)),
			want(ex(iw(OP_SHL, 5'd12, 5'd1, 18'd32), 10'd16),
				res(32'd17, 1'b0, 5'd12, 32'd0, 1'b0, 11'd0, 32'd0)),
			want(ex(iw(OP_SHR, 5'd13, 5'd2, 18'h01FFF), 10'd17),
				res(32'd18, 1'b0, 5'd13, 32'd0, 1'b0, 11'd0, 32'd0)),
			chk(ex(iw(OP_SHR, 5'd14, 5'd2, 18'd1), 10'd18)),
			chk(ex(iw(OP_BNE, 5'd1, 5'd0, 18'h3FFFF), 10'd100)),
			want(ex(iw(OP_BNE, 5'd0, 5'd0, 18'h1FFFF), 10'd1023),
				res(32'd1024, 1'b0, 5'd0, 32'd0, 1'b0, 11'd0, 32'd0)),
			chk(ex(iw(OP_BNE, 5'd2, 5'd1, 18'h1FFFF), 10'd1023)),
			want(ex({OP_JMP, 28'hFFF_FFFF}, 10'd1023),
				res(32'h0FFF_FFFF, 1'b1, 5'd0, 32'd0, 1'b0, 11'd0, 32'd0)),
			chk(ex(iw(OP_STORE, 5'd1, 5'd0, 18'h007FF), 10'd20)),
			chk(ex(iw(OP_STORE, 5'd2, 5'd1, 18'h20001), 10'd21)),
			chk(ex(iw(OP_LOAD, 5'd15, 5'd0, 18'd0), 10'd22)),
			chk(ex(iw(OP_ADD, 5'd15, 5'd15, {5'd16, 13'd0}), 10'd23)),
			want(ex(32'hFFFF_FFFF, 10'd1023),
				res(32'd1024, 1'b0, 5'd0, 32'd0, 1'b0, 11'd0, 32'd0))
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[i]) begin
			drive_beat(plan[i].stim, plan[i].typed, plan[i].want);
			idle_in(pick_gap());
		end
		drain();
		for (int k = 0; k < 750; k++) begin
			if (k % 150 == 0)
				quiet = (k == 300);
			// sender pause until the pipe is empty
			if (k == 450)
				drain();
			drive_beat(draw_item(), 1'b0, '0);
			idle_in(pick_gap());
		end
		drain();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb_risc_instruction_executor_top passed");
		else
			$display("tb_risc_instruction_executor_top failed");
		$finish;
	end

endmodule
